// ----- rtl/nfcl_pkg.sv -----
// Shared types, constants and codes for the NFC tag memory with lock bits.
package nfcl_pkg;

  localparam int TAG_BYTES  = 64;
  localparam int LOCK_LO    = 10;
  localparam int OTP_START  = 12;
  localparam int USER_START = 16;
  localparam int HDR_BYTES  = 9;
  localparam int INT_BYTE   = 9;
  localparam int MEM_DEPTH  = TAG_BYTES - OTP_START;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);
  localparam int QDEPTH     = 2;
  localparam int QAW        = $clog2(QDEPTH);

  localparam logic [7:0] MFR_CODE    = 8'h73;
  localparam logic [7:0] CHECK1_SALT = 8'h99;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_VERIFY = 2'd1,
    OP_LOAD   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RG_OOR,
    RG_HDR,
    RG_LOCK,
    RG_OTP,
    RG_USER
  } region_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  offset;
    logic [7:0]  data_byte;
    logic [47:0] serial;
  } req_t;

  typedef struct packed {
    logic        verify_pass;
    logic [15:0] lock_word;
    logic [7:0]  stored_byte;
  } rsp_t;

  typedef struct packed {
    req_t    req;
    region_e region;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_t;

endpackage

// ----- rtl/nfcl_front.sv -----
// Front end: request intake, offset classification and the command queue.
module nfcl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  nfcl_pkg::req_t      req_i,
  output logic                busy_o,
  input  logic                pop_i,
  output nfcl_pkg::queue_t    q_o
);

  nfcl_pkg::cmd_t                 cmd_in;
  nfcl_pkg::cmd_t                 fifo_q [nfcl_pkg::QDEPTH];
  logic [nfcl_pkg::QAW-1:0]       wptr_q, wptr_d;
  logic [nfcl_pkg::QAW-1:0]       rptr_q, rptr_d;
  logic [nfcl_pkg::QAW:0]         count_q, count_d;
  logic                           push;

  always_comb begin
    cmd_in.req = req_i;
    if (req_i.offset >= 8'(nfcl_pkg::TAG_BYTES)) begin
      cmd_in.region = nfcl_pkg::RG_OOR;
    end else if (req_i.offset < 8'(nfcl_pkg::LOCK_LO)) begin
      cmd_in.region = nfcl_pkg::RG_HDR;
    end else if (req_i.offset < 8'(nfcl_pkg::OTP_START)) begin
      cmd_in.region = nfcl_pkg::RG_LOCK;
    end else if (req_i.offset < 8'(nfcl_pkg::USER_START)) begin
      cmd_in.region = nfcl_pkg::RG_OTP;
    end else begin
      cmd_in.region = nfcl_pkg::RG_USER;
    end
  end

  assign busy_o = (count_q == (nfcl_pkg::QAW+1)'(nfcl_pkg::QDEPTH));
  assign push   = start_i && !busy_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cmd_in;
    end
  end

  assign q_o.valid = (count_q != '0);
  assign q_o.cmd   = fifo_q[rptr_q];

endmodule

// ----- rtl/nfcl_back.sv -----
// Back end: tag store, lock word, header registers and command execution.
module nfcl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nfcl_pkg::queue_t  q_i,
  output logic              pop_o,
  output logic              result_valid_o,
  output nfcl_pkg::rsp_t    result_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                          state_q;
  nfcl_pkg::cmd_t                  cmd_q;
  logic [7:0]                      hdr_q [nfcl_pkg::HDR_BYTES];
  logic [7:0]                      hdr_d [nfcl_pkg::HDR_BYTES];
  logic [15:0]                     lock_q, lock_d;
  logic [7:0]                      mem_q [nfcl_pkg::MEM_DEPTH];
  logic [nfcl_pkg::MEM_DEPTH-1:0]  mem_vld_q;
  logic [7:0]                      rdata_q;
  logic                            rvld_q;
  nfcl_pkg::rsp_t                  rsp_q, rsp_d;
  logic                            rsp_vld_q;

  logic [7:0]                      in_off, ex_off, rd_sub, wr_sub;
  logic [nfcl_pkg::MEM_AW-1:0]     rd_idx, wr_idx;
  logic [7:0]                      old_byte, wdata;
  logic                            wen, clr;
  logic [7:0]                      v;
  logic [47:0]                     s;

  assign pop_o  = (state_q == ST_IDLE) && q_i.valid;
  assign in_off = q_i.cmd.req.offset;
  assign rd_sub = in_off - 8'(nfcl_pkg::OTP_START);
  assign rd_idx = rd_sub[nfcl_pkg::MEM_AW-1:0];
  assign ex_off = cmd_q.req.offset;
  assign wr_sub = ex_off - 8'(nfcl_pkg::OTP_START);
  assign wr_idx = wr_sub[nfcl_pkg::MEM_AW-1:0];
  assign old_byte = rvld_q ? rdata_q : 8'h00;
  assign v = cmd_q.req.data_byte;
  assign s = cmd_q.req.serial;

  always_comb begin
    hdr_d = hdr_q;
    lock_d = lock_q;
    wen = 1'b0;
    clr = 1'b0;
    wdata = v;
    rsp_d = '0;
    unique case (cmd_q.req.op)
      nfcl_pkg::OP_WRITE: begin
        unique case (cmd_q.region)
          nfcl_pkg::RG_LOCK: begin
            if (!ex_off[0]) begin
              lock_d[2:0] = lock_q[2:0] | v[2:0];
              if (!lock_d[0]) begin
                lock_d[3] = lock_q[3] | v[3];
              end
              if (!lock_d[1]) begin
                lock_d[7:4] = lock_q[7:4] | v[7:4];
              end
            end else begin
              if (!lock_q[1]) begin
                lock_d[9:8] = lock_q[9:8] | v[1:0];
              end
              if (!lock_q[2]) begin
                lock_d[15:10] = lock_q[15:10] | v[7:2];
              end
            end
          end
          nfcl_pkg::RG_OTP: begin
            wen   = !lock_q[3];
            wdata = old_byte | v;
          end
          nfcl_pkg::RG_USER: begin
            wen   = !lock_q[ex_off[5:2]];
            wdata = v;
          end
          default: begin
          end
        endcase
      end
      nfcl_pkg::OP_VERIFY: begin
        rsp_d.verify_pass = (hdr_q[0] == nfcl_pkg::MFR_CODE) &&
          ((nfcl_pkg::MFR_CODE ^ hdr_q[1] ^ hdr_q[2] ^ nfcl_pkg::CHECK1_SALT) == hdr_q[3]) &&
          ((hdr_q[4] ^ hdr_q[5] ^ hdr_q[6] ^ hdr_q[7]) == hdr_q[8]);
      end
      nfcl_pkg::OP_LOAD: begin
        hdr_d[0] = nfcl_pkg::MFR_CODE;
        hdr_d[1] = s[7:0];
        hdr_d[2] = s[15:8];
        hdr_d[3] = nfcl_pkg::MFR_CODE ^ s[7:0] ^ s[15:8] ^ nfcl_pkg::CHECK1_SALT;
        hdr_d[4] = s[23:16];
        hdr_d[5] = s[31:24];
        hdr_d[6] = s[39:32];
        hdr_d[7] = s[47:40];
        hdr_d[8] = s[23:16] ^ s[31:24] ^ s[39:32] ^ s[47:40];
      end
      nfcl_pkg::OP_CLEAR: begin
        clr = 1'b1;
        lock_d = '0;
        for (int i = 0; i < nfcl_pkg::HDR_BYTES; i++) begin
          hdr_d[i] = '0;
        end
      end
      default: begin
      end
    endcase

    rsp_d.lock_word = lock_d;
    case (cmd_q.region)
      nfcl_pkg::RG_HDR: begin
        if (ex_off == 8'(nfcl_pkg::INT_BYTE)) begin
          rsp_d.stored_byte = 8'h00;
        end else begin
          rsp_d.stored_byte = hdr_d[ex_off[3:0]];
        end
      end
      nfcl_pkg::RG_LOCK: begin
        rsp_d.stored_byte = ex_off[0] ? lock_d[15:8] : lock_d[7:0];
      end
      nfcl_pkg::RG_OTP, nfcl_pkg::RG_USER: begin
        if (clr) begin
          rsp_d.stored_byte = 8'h00;
        end else begin
          rsp_d.stored_byte = wen ? wdata : old_byte;
        end
      end
      default: begin
        rsp_d.stored_byte = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rsp_vld_q <= 1'b0;
      lock_q    <= '0;
      for (int i = 0; i < nfcl_pkg::HDR_BYTES; i++) begin
        hdr_q[i] <= '0;
      end
    end else begin
      rsp_vld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (q_i.valid) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          lock_q    <= lock_d;
          hdr_q     <= hdr_d;
          rsp_vld_q <= 1'b1;
          state_q   <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_i.cmd;
    end
    if (state_q == ST_EXEC) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        rvld_q <= (q_i.cmd.region == nfcl_pkg::RG_OTP ||
                   q_i.cmd.region == nfcl_pkg::RG_USER) && mem_vld_q[rd_idx];
      end
      if (state_q == ST_EXEC) begin
        if (clr) begin
          mem_vld_q <= '0;
        end else if (wen) begin
          mem_vld_q[wr_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (q_i.cmd.region == nfcl_pkg::RG_OTP ||
                  q_i.cmd.region == nfcl_pkg::RG_USER)) begin
      rdata_q <= mem_q[rd_idx];
    end
    if ((state_q == ST_EXEC) && wen) begin
      mem_q[wr_idx] <= wdata;
    end
  end

  assign result_valid_o = rsp_vld_q;
  assign result_o       = rsp_q;

endmodule

// ----- rtl/nfc_tag_memory_with_locks.sv -----
// Top level of the Type-2 NFC tag memory with lock bits and OTP bytes.
//
// Request channel: drive req_i and raise start_i; the request is taken at the
// rising edge where start_i is high and busy_o is low. busy_o rises only when
// the two-entry command queue is full.
// Result channel: every request yields one result on result_o, marked by
// result_valid_o for exactly one cycle. The receiver cannot stall; results
// must be captured in the cycle they appear.
// Path: a request taken into an empty block passes through the queue, the tag
// store read and the execute step. The back end takes one command at a time,
// as the read-then-write access to the tag store ends before the next pop.
// Reset: rst_ni clears the queue, lock word, header bytes and the valid bits
// of the tag store, so the whole tag reads as zero; requests can be issued
// in the first cycle after reset is released.
module nfc_tag_memory_with_locks (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  nfcl_pkg::req_t   req_i,
  output logic             busy_o,
  output logic             result_valid_o,
  output nfcl_pkg::rsp_t   result_o
);

  nfcl_pkg::queue_t q;
  logic             pop;

  nfcl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .pop_i   (pop),
    .q_o     (q)
  );

  nfcl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_i            (q),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobes in consecutive cycles");

  a_busy_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> q.valid)
    else $error("queue full but no command offered");

  a_result_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(pop, 2))
    else $error("result without a command taken from the queue");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q.valid)
    else $error("command taken from an empty queue");

endmodule
